// ----- design/cfe_pkg.sv -----
`timescale 1ns / 1ps

package cfe_pkg;

	// frame shape defaults
	localparam int ANGLE_REPEATS_DEF   = 2;
	localparam int SPEED_REPEATS_DEF   = 2;
	localparam int PREAMBLE_LENGTH_DEF = 9;
	localparam int SPLIT_LENGTH        = 9;

	// field widths
	localparam int VALUE_W  = 12;
	localparam int MODE_W   = 2;
	localparam int WORD_W   = 16;
	localparam int CODE_W   = 6;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// speed word constants
	localparam logic [WORD_W-1:0] DISABLED_WORD = 16'd777;
	localparam logic [WORD_W-1:0] DIRECT_OFFSET = 16'd900;
	localparam int                SIGN_POS      = 10;

	// speed modes
	localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_START   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_START = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT       = 3'd6;

	// register reset values
	localparam logic [4:0]  SPEED_SCALE_RST = 5'd5;
	localparam logic [10:0] SPEED_LIMIT_RST = 11'd1000;
	localparam logic [10:0] ANGLE_LIMIT_RST = 11'd1023;
	localparam logic [7:0]  CRC_START_RST   = 8'd0;
	localparam logic [7:0]  PREAMBLE_RST    = 8'd255;
	localparam logic [7:0]  GROUP_START_RST = 8'd128;
	localparam logic [7:0]  SPLIT_RST       = 8'd254;

	typedef logic [CODE_W-1:0] code_byte_t;
	typedef code_byte_t [3:0] code_set_t;

	typedef struct packed {
		logic [4:0]  speed_scale;
		logic [10:0] speed_limit;
		logic [10:0] angle_limit;
		logic [7:0]  crc_start;
		logic [7:0]  preamble_byte;
		logic [7:0]  group_start_byte;
		logic [7:0]  split_byte;
	} cfg_t;

endpackage

// ----- design/cfe_code_lane.sv -----
`timescale 1ns / 1ps

module cfe_code_lane (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cfe_pkg::WORD_W-1:0]   word,
	input  logic [7:0]                   crc_start,
	output cfe_pkg::code_set_t           codes_s3
);
	import cfe_pkg::*;

	// crc-8, poly 0x07, msb first, one byte
	function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// hamming(15,11): parity at 0, 1, 3, 7
	function automatic logic [14:0] hamming15(input logic [10:0] d);
		logic [14:0] c;
		c = '0;
		c[2]    = d[0];
		c[6:4]  = d[3:1];
		c[14:8] = d[10:4];
		c[0] = c[2] ^ c[4] ^ c[6] ^ c[8] ^ c[10] ^ c[12] ^ c[14];
		c[1] = c[2] ^ c[5] ^ c[6] ^ c[9] ^ c[10] ^ c[13] ^ c[14];
		c[3] = c[4] ^ c[5] ^ c[6] ^ c[11] ^ c[12] ^ c[13] ^ c[14];
		c[7] = c[8] ^ c[9] ^ c[10] ^ c[11] ^ c[12] ^ c[13] ^ c[14];
		return c;
	endfunction

	logic [7:0]  crc;
	logic [14:0] h;

	// check bits of the word
	always_comb begin
		crc = crc_byte(crc_byte(crc_start, word[15:8]), word[7:0]);
		h   = hamming15(word[10:0]);
	end

	// pack into four 6-bit code bytes
	always_ff @(posedge clk) begin
		if (en) begin
			codes_s3[0] <= h[14:9];
			codes_s3[1] <= h[8:3];
			codes_s3[2] <= {h[2:0], crc[7], crc[7], crc[6]};
			codes_s3[3] <= crc[5:0];
		end
	end

endmodule

// ----- design/cfe_frame_out.sv -----
`timescale 1ns / 1ps

module cfe_frame_out #(
	parameter int ANGLE_REPEATS   = cfe_pkg::ANGLE_REPEATS_DEF,
	parameter int SPEED_REPEATS   = cfe_pkg::SPEED_REPEATS_DEF,
	parameter int PREAMBLE_LENGTH = cfe_pkg::PREAMBLE_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	output logic               can_load,
	input  cfe_pkg::code_set_t angle_codes,
	input  cfe_pkg::code_set_t speed_codes,
	input  logic [7:0]         preamble_byte,
	input  logic [7:0]         group_start_byte,
	input  logic [7:0]         split_byte,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // frame_byte [7:0]
	output logic               m_tlast
);
	import cfe_pkg::*;

	typedef enum logic [3:0] {
		SEG_PRE = 4'b0001,
		SEG_ANG = 4'b0010,
		SEG_SPL = 4'b0100,
		SEG_SPD = 4'b1000
	} seg_t;

	seg_t       seg_q;
	logic       busy_q;
	logic [3:0] cnt_q;
	logic [2:0] idx_q;
	logic [1:0] rep_q;
	code_set_t  acode_q;
	code_set_t  scode_q;
	code_set_t  cur_codes;
	logic       fire;

	assign m_tvalid = busy_q;
	assign fire     = busy_q && m_tready;
	assign m_tlast  = (seg_q == SEG_SPD) && (rep_q == 2'(SPEED_REPEATS)) && (idx_q == 3'd4);
	assign can_load = !busy_q || (fire && m_tlast);

	// byte select for the current position
	always_comb begin
		cur_codes = (seg_q == SEG_ANG) ? acode_q : scode_q;
		case (seg_q)
			SEG_PRE: m_tdata = preamble_byte;
			SEG_SPL: m_tdata = split_byte;
			default: begin
				case (idx_q)
					3'd1:    m_tdata = {2'b00, cur_codes[0]};
					3'd2:    m_tdata = {2'b00, cur_codes[1]};
					3'd3:    m_tdata = {2'b00, cur_codes[2]};
					3'd4:    m_tdata = {2'b00, cur_codes[3]};
					default: m_tdata = group_start_byte;
				endcase
			end
		endcase
	end

	// code words of the frame being sent
	always_ff @(posedge clk) begin
		if (load && can_load) begin
			acode_q <= angle_codes;
			scode_q <= speed_codes;
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= SEG_PRE;
			cnt_q  <= '0;
			idx_q  <= '0;
			rep_q  <= '0;
		end else if (load && can_load) begin
			busy_q <= 1'b1;
			seg_q  <= SEG_PRE;
			cnt_q  <= '0;
			idx_q  <= '0;
			rep_q  <= '0;
		end else if (fire) begin
			case (seg_q)
				SEG_PRE: begin
					if (cnt_q == 4'(PREAMBLE_LENGTH - 1)) begin
						seg_q <= SEG_ANG;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				SEG_ANG: begin
					if (idx_q == 3'd4) begin
						idx_q <= '0;
						if (rep_q == 2'(ANGLE_REPEATS)) begin
							seg_q <= SEG_SPL;
							rep_q <= '0;
						end else begin
							rep_q <= rep_q + 2'd1;
						end
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				SEG_SPL: begin
					if (cnt_q == 4'(SPLIT_LENGTH - 1)) begin
						seg_q <= SEG_SPD;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: begin
					if (idx_q == 3'd4) begin
						idx_q <= '0;
						if (rep_q == 2'(SPEED_REPEATS)) begin
							busy_q <= 1'b0;
							rep_q  <= '0;
						end else begin
							rep_q <= rep_q + 2'd1;
						end
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
			endcase
		end
	end

endmodule

// ----- design/command_frame_encoder_unit.sv -----
`timescale 1ns / 1ps
// Command frame encoder: one speed/angle command in, one byte frame out.
// Input channel s_*: one word per command (speed value, angle value, speed mode).
// Output channel m_*: the frame, one byte per word, m_tlast on its final byte.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock edge;
// write only while no frame is pending or in flight.
// A frame has PREAMBLE_LENGTH + 9 + 5*(ANGLE_REPEATS+1) + 5*(SPEED_REPEATS+1)
// bytes, 48 at the defaults; the frame serializer sends one byte per cycle while
// m_tready is high and sets the throughput.
// A command passes the magnitude/scale stage, the word stage and two code lanes
// with CRC-8 and Hamming, then the serializer. Up to three further commands wait
// in the pipeline, so frames can follow each other back to back.
// When the receiver drops m_tready the current byte holds and the pipeline fills,
// after which s_tready goes low.
// Reset clears the pipeline and the serializer and loads the register defaults.
module command_frame_encoder_unit #(
	parameter int ANGLE_REPEATS   = cfe_pkg::ANGLE_REPEATS_DEF,
	parameter int SPEED_REPEATS   = cfe_pkg::SPEED_REPEATS_DEF,
	parameter int PREAMBLE_LENGTH = cfe_pkg::PREAMBLE_LENGTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // speed_value [11:0], angle_value [23:12],
	                                                    // speed_mode [25:24], zeros above
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // frame_byte [7:0]
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [cfe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfe_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import cfe_pkg::*;

	cfg_t cfg_q;

	logic               v_s1, v_s2, v_s3;
	logic               adv1, adv2, adv3, rdy2, rdy3, can_load;
	logic [VALUE_W-1:0] speed_in, angle_in, smag, amag;
	logic [MODE_W-1:0]  mode_in;
	logic [16:0]        prod;

	logic [WORD_W-1:0]  prod_s1;
	logic [VALUE_W-1:0] amag_s1;
	logic               sneg_s1, aneg_s1;
	logic [MODE_W-1:0]  mode_s1;

	logic [WORD_W-1:0]  sword, aword, sword_s2, aword_s2;
	code_set_t          scode_s3, acode_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_scale      <= SPEED_SCALE_RST;
			cfg_q.speed_limit      <= SPEED_LIMIT_RST;
			cfg_q.angle_limit      <= ANGLE_LIMIT_RST;
			cfg_q.crc_start        <= CRC_START_RST;
			cfg_q.preamble_byte    <= PREAMBLE_RST;
			cfg_q.group_start_byte <= GROUP_START_RST;
			cfg_q.split_byte       <= SPLIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_SCALE: cfg_q.speed_scale      <= cfg_data[4:0];
				REG_SPEED_LIMIT: cfg_q.speed_limit      <= cfg_data;
				REG_ANGLE_LIMIT: cfg_q.angle_limit      <= cfg_data;
				REG_CRC_START:   cfg_q.crc_start        <= cfg_data[7:0];
				REG_PREAMBLE:    cfg_q.preamble_byte    <= cfg_data[7:0];
				REG_GROUP_START: cfg_q.group_start_byte <= cfg_data[7:0];
				REG_SPLIT:       cfg_q.split_byte       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	assign rdy3     = !v_s3 || can_load;
	assign adv3     = v_s2 && rdy3;
	assign rdy2     = !v_s2 || adv3;
	assign adv2     = v_s1 && rdy2;
	assign s_tready = !v_s1 || adv2;
	assign adv1     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1)      v_s1 <= 1'b1;
			else if (adv2) v_s1 <= 1'b0;
			if (adv2)      v_s2 <= 1'b1;
			else if (adv3) v_s2 <= 1'b0;
			if (adv3)          v_s3 <= 1'b1;
			else if (can_load) v_s3 <= 1'b0;
		end
	end

	// stage 1: magnitudes and scaled speed
	always_comb begin
		speed_in = s_tdata[11:0];
		angle_in = s_tdata[23:12];
		mode_in  = s_tdata[25:24];
		smag     = speed_in[VALUE_W-1] ? (~speed_in + 12'd1) : speed_in;
		amag     = angle_in[VALUE_W-1] ? (~angle_in + 12'd1) : angle_in;
		prod     = 17'(cfg_q.speed_scale) * 17'(smag);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s1 <= prod[15:0];
			sneg_s1 <= speed_in[VALUE_W-1];
			aneg_s1 <= angle_in[VALUE_W-1];
			amag_s1 <= amag;
			mode_s1 <= mode_in;
		end
	end

	// stage 2: speed and angle words
	always_comb begin
		case (mode_s1)
			MODE_NORMAL: begin
				sword = (prod_s1 > 16'(cfg_q.speed_limit)) ? 16'(cfg_q.speed_limit) : prod_s1;
				sword[SIGN_POS] = sword[SIGN_POS] | sneg_s1;
			end
			MODE_DIRECT: begin
				sword = prod_s1 + DIRECT_OFFSET;
				sword[SIGN_POS] = sword[SIGN_POS] | sneg_s1;
			end
			default: sword = DISABLED_WORD;
		endcase
		aword = (amag_s1 > 12'(cfg_q.angle_limit)) ? 16'(cfg_q.angle_limit) : 16'(amag_s1);
		aword[SIGN_POS] = aword[SIGN_POS] | aneg_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sword_s2 <= sword;
			aword_s2 <= aword;
		end
	end

	// stage 3: code lanes, one per word
	cfe_code_lane u_speed_lane (
		.clk       (clk),
		.en        (adv3),
		.word      (sword_s2),
		.crc_start (cfg_q.crc_start),
		.codes_s3  (scode_s3)
	);

	cfe_code_lane u_angle_lane (
		.clk       (clk),
		.en        (adv3),
		.word      (aword_s2),
		.crc_start (cfg_q.crc_start),
		.codes_s3  (acode_s3)
	);

	// merge both lanes into the byte frame
	cfe_frame_out #(
		.ANGLE_REPEATS   (ANGLE_REPEATS),
		.SPEED_REPEATS   (SPEED_REPEATS),
		.PREAMBLE_LENGTH (PREAMBLE_LENGTH)
	) u_frame_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (v_s3),
		.can_load         (can_load),
		.angle_codes      (acode_s3),
		.speed_codes      (scode_s3),
		.preamble_byte    (cfg_q.preamble_byte),
		.group_start_byte (cfg_q.group_start_byte),
		.split_byte       (cfg_q.split_byte),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast)
	);

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import cfe_pkg::*;

	// speed modes that the package leaves unnamed
	localparam logic [MODE_W-1:0]    MODE_OFF       = 2'd2;
	localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;
	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;

	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int SHOWN_ERRORS   = 10;
	localparam int SETTINGS_PER_PHASE = 4;
	localparam int WORDS_PER_SETTING  = 28;
	localparam int FRAME_LEN = PREAMBLE_LENGTH_DEF + SPLIT_LENGTH
				 + 5 * (ANGLE_REPEATS_DEF + 1) + 5 * (SPEED_REPEATS_DEF + 1);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copy used for prediction
	cfg_t regs;
	frame_byte_t expected_bytes[$];

	int src_idle_pct = 23;
	int snk_idle_pct = 79;
	int mismatches = 0;
	int bytes_checked = 0;
	int commands_sent = 0;
	int settings_used = 0;
	int quiet_cycles = 0;

	command_frame_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // speed_value [11:0], angle_value [23:12], speed_mode [25:24]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // frame_byte [7:0]
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// random receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// crc-8, polynomial 0x07, msb first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		for (int k = 0; k < 8; k++)
			r = r[7] ? ({r[6:0], 1'b0} ^ 8'h07) : {r[6:0], 1'b0};
		return r;
	endfunction

	// hamming(15,11): parity at 0, 1, 3, 7
	function automatic logic [14:0] hamming15(input logic [10:0] d);
		logic [14:0] c;
		c = '0;
		c[2] = d[0];
		c[6:4] = d[3:1];
		c[14:8] = d[10:4];
		c[0] = c[2] ^ c[4] ^ c[6] ^ c[8] ^ c[10] ^ c[12] ^ c[14];
		c[1] = c[2] ^ c[5] ^ c[6] ^ c[9] ^ c[10] ^ c[13] ^ c[14];
		c[3] = c[4] ^ c[5] ^ c[6] ^ c[11] ^ c[12] ^ c[13] ^ c[14];
		c[7] = c[8] ^ c[9] ^ c[10] ^ c[11] ^ c[12] ^ c[13] ^ c[14];
		return c;
	endfunction

	// four 6-bit code bytes of a 16-bit word
	function automatic code_set_t code_bytes(input logic [15:0] w);
		logic [7:0] crc;
		logic [14:0] h;
		code_set_t cs;
		crc = crc8_step(regs.crc_start, w[15:8]);
		crc = crc8_step(crc, w[7:0]);
		h = hamming15(w[10:0]);
		cs[0] = h[14:9];
		cs[1] = h[8:3];
		cs[2] = {h[2:0], crc[7], crc[7:6]};
		cs[3] = crc[5:0];
		return cs;
	endfunction

	// expected frame of one command word, appended to expected_bytes
	function automatic void predict_frame(input logic [11:0] spd, input logic [11:0] ang,
					      input logic [1:0] mode);
		logic sneg, aneg;
		logic [12:0] smag, amag;
		logic [31:0] prod;
		logic [15:0] sword, aword;
		code_set_t scode, acode;
		logic [7:0] fr[FRAME_LEN];
		int n;
		frame_byte_t fb;
		sneg = spd[11];
		smag = sneg ? 13'h1000 - {1'b0, spd} : {1'b0, spd};
		prod = 32'(regs.speed_scale) * 32'(smag);
		sword = prod[15:0];
		case (mode)
			MODE_NORMAL: begin
				if (sword > 16'(regs.speed_limit))
					sword = 16'(regs.speed_limit);
				if (sneg)
					sword[SIGN_POS] = 1'b1;
			end
			MODE_DIRECT: begin
				sword = sword + DIRECT_OFFSET;
				if (sneg)
					sword[SIGN_POS] = 1'b1;
			end
			default: begin
				sword = DISABLED_WORD;
			end
		endcase
		aneg = ang[11];
		amag = aneg ? 13'h1000 - {1'b0, ang} : {1'b0, ang};
		aword = (amag > 13'(regs.angle_limit)) ? 16'(regs.angle_limit) : 16'(amag);
		if (aneg)
			aword[SIGN_POS] = 1'b1;
		scode = code_bytes(sword);
		acode = code_bytes(aword);

		n = 0;
		repeat (PREAMBLE_LENGTH_DEF) begin
			fr[n] = regs.preamble_byte;
			n++;
		end
		repeat (ANGLE_REPEATS_DEF + 1) begin
			fr[n] = regs.group_start_byte;
			n++;
			for (int k = 0; k < 4; k++) begin
				fr[n] = {2'b00, acode[k]};
				n++;
			end
		end
		repeat (SPLIT_LENGTH) begin
			fr[n] = regs.split_byte;
			n++;
		end
		repeat (SPEED_REPEATS_DEF + 1) begin
			fr[n] = regs.group_start_byte;
			n++;
			for (int k = 0; k < 4; k++) begin
				fr[n] = {2'b00, scode[k]};
				n++;
			end
		end
		for (int i = 0; i < FRAME_LEN; i++) begin
			fb.value = fr[i];
			fb.last = (i == FRAME_LEN - 1);
			expected_bytes.insert(expected_bytes.size(), fb);
		end
	endfunction

	// register value, ends of the range more often
	function automatic logic [10:0] pick_reg(input int lo, input int hi);
		case ($urandom_range(0, 5))
			0: return 11'(lo);
			1: return 11'(hi);
			default: return 11'($urandom_range(lo, hi));
		endcase
	endfunction

	// command value: extremes, values around a clamp knee, or anything
	function automatic logic [11:0] pick_value(input logic [11:0] knee);
		logic [11:0] v;
		case ($urandom_range(0, 7))
			0: v = 12'h800;
			1: v = 12'h7FF;
			2: begin
				v = knee + 12'($urandom_range(0, 2)) - 12'd1;
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = 12'($urandom);
		endcase
		return v;
	endfunction

	// send one command word, with random idle cycles ahead of it
	task automatic send_command(input logic [11:0] spd, input logic [11:0] ang,
				    input logic [1:0] mode);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, mode, ang, spd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_frame(spd, ang, mode);
		commands_sent++;
	endtask

	// one register write, cfg_we left high for a following write
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SPEED_SCALE: regs.speed_scale = val[4:0];
			REG_SPEED_LIMIT: regs.speed_limit = val[10:0];
			REG_ANGLE_LIMIT: regs.angle_limit = val[10:0];
			REG_CRC_START:   regs.crc_start = val[7:0];
			REG_PREAMBLE:    regs.preamble_byte = val[7:0];
			REG_GROUP_START: regs.group_start_byte = val[7:0];
			REG_SPLIT:       regs.split_byte = val[7:0];
			default: ;
		endcase
	endtask

	// full register set, unused upper data bits random
	task automatic program_regs(input cfg_t c);
		put_reg(REG_SPEED_SCALE, {6'($urandom), c.speed_scale});
		put_reg(REG_SPEED_LIMIT, c.speed_limit);
		put_reg(REG_ANGLE_LIMIT, c.angle_limit);
		put_reg(REG_CRC_START, {3'($urandom), c.crc_start});
		put_reg(REG_PREAMBLE, {3'($urandom), c.preamble_byte});
		put_reg(REG_GROUP_START, {3'($urandom), c.group_start_byte});
		put_reg(REG_SPLIT, {3'($urandom), c.split_byte});
		put_reg(REG_UNUSED_IDX, 11'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// stop sending and let every pending frame drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// reset register values, extremes of the fields, every mode
	task automatic test_directed_defaults();
		send_command(12'h000, 12'h000, MODE_NORMAL);
		send_command(12'h7FF, 12'h7FF, MODE_NORMAL);
		send_command(12'h801, 12'h801, MODE_NORMAL);
		send_command(12'h800, 12'h800, MODE_NORMAL);
		send_command(12'hFFF, 12'h001, MODE_NORMAL);
		send_command(12'd200, -12'd1023, MODE_NORMAL);
		send_command(12'd201, 12'd1023, MODE_NORMAL);
		send_command(12'hAAA, 12'h555, MODE_NORMAL);
		send_command(12'h000, 12'd1024, MODE_DIRECT);
		send_command(12'h7FF, 12'h800, MODE_DIRECT);
		send_command(12'h800, 12'd5, MODE_DIRECT);
		send_command(12'hFFF, 12'h000, MODE_DIRECT);
		send_command(12'd1234, 12'd321, MODE_OFF);
		send_command(-12'd5, -12'd6, MODE_SPARE);
		send_command(12'h555, 12'hAAA, MODE_SPARE);
	endtask

	// all registers at their lowest, then at their highest
	task automatic test_register_extremes();
		cfg_t c;
		wait_idle();
		c = '0;
		program_regs(c);
		send_command(12'h7FF, 12'h7FF, MODE_NORMAL);
		send_command(12'h800, 12'h800, MODE_DIRECT);
		send_command(12'hFFF, 12'h001, MODE_NORMAL);
		send_command(12'd5, -12'd5, MODE_OFF);
		wait_idle();
		c = '1;
		program_regs(c);
		send_command(12'h7FF, 12'h800, MODE_NORMAL);
		send_command(12'h800, 12'h7FF, MODE_DIRECT);
		send_command(12'h7FF, 12'h000, MODE_DIRECT);
		send_command(12'd100, -12'd100, MODE_NORMAL);
	endtask

	// random settings and commands under three idle profiles
	task automatic test_random_traffic();
		cfg_t c;
		logic [11:0] knee;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 23;
					snk_idle_pct = 79;
				end
				1: begin
					src_idle_pct = 79;
					snk_idle_pct = 23;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
				wait_idle();
				c.speed_scale = 5'(pick_reg(1, 16));
				c.speed_limit = pick_reg(0, 2047);
				c.angle_limit = pick_reg(0, 2047);
				c.crc_start = 8'(pick_reg(0, 255));
				c.preamble_byte = 8'(pick_reg(0, 255));
				c.group_start_byte = 8'(pick_reg(0, 255));
				c.split_byte = 8'(pick_reg(0, 255));
				program_regs(c);
				knee = 12'(regs.speed_limit / regs.speed_scale);
				for (int n = 0; n < WORDS_PER_SETTING + s; n++)
					send_command(pick_value(knee), pick_value(12'(regs.angle_limit)),
						     2'($urandom_range(0, 3)));
			end
		end
	endtask

	// frame check and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no word moved for %0d cycles, %0d bytes still expected",
					 STALL_LIMIT, expected_bytes.size());
				$display("tb NOT OK");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					if (mismatches < SHOWN_ERRORS)
						$display("unexpected frame byte %02h last %b", m_tdata, m_tlast);
					mismatches++;
				end else begin
					frame_byte_t exp_b;
					exp_b = expected_bytes.pop_front();
					if (m_tdata !== exp_b.value || m_tlast !== exp_b.last) begin
						if (mismatches < SHOWN_ERRORS)
							$display("frame byte %0d: expected %02h last %b, got %02h last %b",
								 bytes_checked, exp_b.value, exp_b.last, m_tdata, m_tlast);
						mismatches++;
					end
					bytes_checked++;
				end
			end
		end
	end

	initial begin
		regs.speed_scale = SPEED_SCALE_RST;
		regs.speed_limit = SPEED_LIMIT_RST;
		regs.angle_limit = ANGLE_LIMIT_RST;
		regs.crc_start = CRC_START_RST;
		regs.preamble_byte = PREAMBLE_RST;
		regs.group_start_byte = GROUP_START_RST;
		regs.split_byte = SPLIT_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_register_extremes();
		test_random_traffic();
		wait_idle();

		$display("%0d commands over %0d register settings, %0d frame bytes compared",
			 commands_sent, settings_used, bytes_checked);
		$display("all speed modes incl. the spare one, field and register extremes, %0d mismatches",
			 mismatches);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
